@@ rtl/swah_pkg.sv @@
// ----------------------------------------------------------------------------
// swah_pkg
// Shared types, sizes and helpers for the strand-aware window histogram.
// ----------------------------------------------------------------------------
package swah_pkg;

	localparam int unsigned HALF_WINDOW = 512;
	localparam int unsigned WIN_SIZE    = 2 * HALF_WINDOW;
	localparam int unsigned ADDR_W      = $clog2(WIN_SIZE);

	localparam int unsigned POS_W   = 32;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned READS_W = 16;
	localparam int unsigned SEL_W   = 10;
	localparam int unsigned BIN_W   = 11;
	localparam int unsigned PROD_W  = LEVEL_W + READS_W;
	localparam int unsigned REL_W   = POS_W + 2;
	localparam int unsigned PTR_W   = SEL_W + BIN_W + 1;

	localparam int unsigned WSUM_W  = 48;
	localparam int unsigned RSUM_W  = 32;
	localparam int unsigned SSUM_W  = 32;
	localparam int unsigned ENTRY_W = WSUM_W + RSUM_W + SSUM_W;

	localparam logic [BIN_W-1:0] BIN_WIDTH_RESET = BIN_W'(50);

	localparam logic REQ_ACC  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [POS_W-1:0]   anchor_pos;
		logic               anchor_plus_strand;
		logic [POS_W-1:0]   site_pos;
		logic [LEVEL_W-1:0] site_level;
		logic [READS_W-1:0] site_reads;
		logic [SEL_W-1:0]   bin_select;
	} req_t;

	typedef struct packed {
		logic              in_window;
		logic [WSUM_W-1:0] bin_weighted_sum;
		logic [RSUM_W-1:0] bin_read_total;
		logic [SSUM_W-1:0] bin_site_total;
	} rsp_t;

	typedef struct packed {
		logic [WSUM_W-1:0] wsum;
		logic [RSUM_W-1:0] rsum;
		logic [SSUM_W-1:0] ssum;
	} entry_t;

	function automatic logic [WSUM_W-1:0] sat_add_w(input logic [WSUM_W-1:0] a,
			input logic [WSUM_W-1:0] b);
		logic [WSUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
	endfunction

	function automatic logic [RSUM_W-1:0] sat_add_r(input logic [RSUM_W-1:0] a,
			input logic [RSUM_W-1:0] b);
		logic [RSUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[RSUM_W] ? {RSUM_W{1'b1}} : s[RSUM_W-1:0];
	endfunction

endpackage

@@ rtl/swah_ram.sv @@
// ----------------------------------------------------------------------------
// swah_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swah_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/swah_ctrl.sv @@
// ----------------------------------------------------------------------------
// swah_ctrl
// Sequencer: store clearing, window test, read-modify-write of one entry,
// bin scan with saturating sums, and the result register.
// ----------------------------------------------------------------------------
module swah_ctrl
	import swah_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic              req_valid,
	output logic              req_stall,
	output rsp_t              rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic [BIN_W-1:0]  bin_width,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output entry_t            ram_wdata,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  entry_t            ram_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [BIN_W-1:0]    cnt_q;
	logic                rd_v_s1;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                hit_s1;
	logic [ADDR_W-1:0]   off_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [READS_W-1:0]  reads_s1;
	logic [WSUM_W-1:0]   acc_w_q;
	logic [RSUM_W-1:0]   acc_r_q;
	logic [SSUM_W-1:0]   acc_s_q;

	logic                accept;
	logic                slot_free;
	logic                rsp_load;
	logic [REL_W-1:0]    rel;
	logic                hit;
	logic [ADDR_W-1:0]   off;
	logic [BIN_W-1:0]    width_eff;
	logic [PTR_W-1:0]    start;
	logic                issue;
	entry_t              upd;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = ((state_q == ST_ACC) || (state_q == ST_DRAIN)) && slot_free;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// window test and strand mirroring
	always_comb begin
		rel = {2'b00, req.site_pos} - {2'b00, req.anchor_pos} + REL_W'(HALF_WINDOW);
		hit = !rel[REL_W-1] && (rel < REL_W'(WIN_SIZE));
		off = req.anchor_plus_strand ? rel[ADDR_W-1:0]
			: ADDR_W'(WIN_SIZE - 1) - rel[ADDR_W-1:0];
	end

	assign width_eff = (bin_width == '0) ? BIN_W'(1) : bin_width;
	assign start     = PTR_W'(req.bin_select * width_eff);
	assign issue     = (cnt_q != '0) && (ptr_q < PTR_W'(WIN_SIZE));

	always_comb begin
		upd.wsum = sat_add_w(ram_rdata.wsum, WSUM_W'(prod_s1));
		upd.rsum = sat_add_r(ram_rdata.rsum, RSUM_W'(reads_s1));
		upd.ssum = sat_add_r(ram_rdata.ssum, SSUM_W'(1));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = off_s1;
		ram_wdata = upd;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_ACC && slot_free && hit_s1) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		if (state_q == ST_SCAN) begin
			ram_re    = issue;
			ram_raddr = ptr_q[ADDR_W-1:0];
		end else begin
			ram_re    = accept && (req.req_type == REQ_ACC) && hit;
			ram_raddr = off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(WIN_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_ACC) begin
							state_q <= ST_ACC;
						end else begin
							ptr_q   <= start;
							cnt_q   <= width_eff;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_ACC: begin
					if (slot_free) begin
						rsp_q   <= {hit_s1, {WSUM_W{1'b0}}, {RSUM_W{1'b0}},
							{SSUM_W{1'b0}}};
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rd_v_s1 <= issue;
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (slot_free) begin
						rsp_q   <= {1'b0, acc_w_q, acc_r_q, acc_s_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// accumulate operands and bin sums
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= hit;
			off_s1   <= off;
			prod_s1  <= req.site_level * req.site_reads;
			reads_s1 <= req.site_reads;
			acc_w_q  <= '0;
			acc_r_q  <= '0;
			acc_s_q  <= '0;
		end else if (rd_v_s1) begin
			acc_w_q <= sat_add_w(acc_w_q, ram_rdata.wsum);
			acc_r_q <= sat_add_r(acc_r_q, ram_rdata.rsum);
			acc_s_q <= sat_add_r(acc_s_q, ram_rdata.ssum);
		end
	end

endmodule

@@ rtl/strand_aware_window_histogram.sv @@
// ----------------------------------------------------------------------------
// strand_aware_window_histogram
// Position histogram around an anchor, kept in one on-chip RAM.
// ----------------------------------------------------------------------------
// Request beats arrive on req with req_valid, held off by req_stall. An
// accumulate beat tests the site against the 2*HALF_WINDOW window around the
// anchor (mirrored for a minus-strand anchor) and, on a hit, adds
// level*reads, reads and one to the entry at that offset. A readout beat
// sums bin_width consecutive entries starting at bin_select*bin_width.
// One response beat per request leaves on rsp with rsp_valid.
// Accumulate: on a hit, one RAM read as the request is taken and one
// write-back as the response is registered, once the result register is
// free. Readout: one RAM read per entry of the bin inside the window (a
// zero bin_width counts as one); the sum is registered in ST_DRAIN once
// the result register is free. One request is in work at a time. The
// result register lets a new request in while a response waits.
// After reset all WIN_SIZE (1024) RAM entries are zeroed with req_stall
// high; cfg writes (always ready) are taken at any time.
// A stalled response holds its payload; the block waits to finish the next
// request until the response register is free.
// ----------------------------------------------------------------------------
module strand_aware_window_histogram
	import swah_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             req_valid,
	output logic             req_stall,
	output rsp_t             rsp,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [BIN_W-1:0] cfg_data
);

	logic [BIN_W-1:0]  bin_width_q;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	entry_t            ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= BIN_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bin_width_q <= cfg_data;
		end
	end

	swah_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.bin_width (bin_width_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	swah_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WIN_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ rtl/swah_checker.sv @@
// ----------------------------------------------------------------------------
// swah_checker
// Port-level checks for the strand-aware window histogram, bound to the top.
// ----------------------------------------------------------------------------
module swah_checker
	import swah_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input rsp_t rsp,
	input logic rsp_valid,
	input logic rsp_stall
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in work");

	// an in-window (accumulate hit) response carries no sums
	a_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.in_window |-> rsp.bin_weighted_sum == '0
			&& rsp.bin_read_total == '0 && rsp.bin_site_total == '0)
		else $error("accumulate response with nonzero sums");

	// a new response only comes out of a cycle with work in progress
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without work in progress");

endmodule

bind strand_aware_window_histogram swah_checker u_swah_checker (.*);
